>>> rtl/pda_pkg.sv
`default_nettype none

package pda_pkg;

   // register file
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] REG_HOMESTEAD      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BYZANTIUM      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CONSTANTINOPLE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MUIR_GLACIER   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LONDON         = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ARROW_GLACIER  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GRAY_GLACIER   = 3'd6;

   localparam logic [31:0] NEVER_BLOCK = 32'hFFFF_FFFF;

   // bomb delays
   localparam int DELAY_BITS = 24;
   localparam logic [DELAY_BITS-1:0] DELAY_GRAY_GLACIER  = 24'd11_400_000;
   localparam logic [DELAY_BITS-1:0] DELAY_ARROW_GLACIER = 24'd10_700_000;
   localparam logic [DELAY_BITS-1:0] DELAY_LONDON        = 24'd9_700_000;
   localparam logic [DELAY_BITS-1:0] DELAY_MUIR_GLACIER  = 24'd9_000_000;
   localparam logic [DELAY_BITS-1:0] DELAY_CONSTANTINOPLE = 24'd5_000_000;
   localparam logic [DELAY_BITS-1:0] DELAY_BYZANTIUM     = 24'd3_000_000;

   // adjustment constants
   localparam logic [6:0]  FRONTIER_FAST_DT = 7'd13;
   localparam logic [6:0]  ADJ_FLOOR        = 7'd99;
   localparam logic [12:0] RECIP_DIV9       = 13'd7282;   // ceil(2^16/9)
   localparam logic [12:0] RECIP_DIV10      = 13'd6554;   // ceil(2^16/10)
   localparam logic [23:0] RECIP_PERIOD     = 24'd10995117; // ceil(2^40/100000)
   localparam logic [31:0] MIN_DIFF         = 32'h0002_0000;

   // classified header waiting in the queue
   typedef struct packed {
      logic [31:0]           block_number;
      logic [DELAY_BITS-1:0] delay;
      logic [31:0]           dt;
      logic [63:0]           parent_diff;
      logic                  uncles;
      logic                  is_byz;
      logic                  is_home;
      logic                  frontier_fast;
   } pda_item_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;

endpackage

`default_nettype wire

>>> rtl/pda_front.sv
`default_nettype none

module pda_front
   import pda_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  wire logic [31:0]               block_number,
   input  wire logic [31:0]               block_time,
   input  wire logic [31:0]               parent_time,
   input  wire logic [63:0]               parent_diff,
   input  wire logic                      parent_uncles,
   output pda_item_type                   item
);

   logic [31:0] homestead_ff, byzantium_ff, constantinople_ff, muir_glacier_ff;
   logic [31:0] london_ff, arrow_glacier_ff, gray_glacier_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         homestead_ff      <= NEVER_BLOCK;
         byzantium_ff      <= NEVER_BLOCK;
         constantinople_ff <= NEVER_BLOCK;
         muir_glacier_ff   <= NEVER_BLOCK;
         london_ff         <= NEVER_BLOCK;
         arrow_glacier_ff  <= NEVER_BLOCK;
         gray_glacier_ff   <= NEVER_BLOCK;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_HOMESTEAD:      homestead_ff      <= csr_wdata;
            REG_BYZANTIUM:      byzantium_ff      <= csr_wdata;
            REG_CONSTANTINOPLE: constantinople_ff <= csr_wdata;
            REG_MUIR_GLACIER:   muir_glacier_ff   <= csr_wdata;
            REG_LONDON:         london_ff         <= csr_wdata;
            REG_ARROW_GLACIER:  arrow_glacier_ff  <= csr_wdata;
            REG_GRAY_GLACIER:   gray_glacier_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   function automatic logic active(input logic [31:0] bn, input logic [31:0] start);
      return (start != NEVER_BLOCK) && (bn >= start);
   endfunction

   logic act_london, act_const, act_byz, act_home, act_muir, act_arrow, act_gray;
   logic [31:0] dt;

   always_comb begin
      act_london = active(block_number, london_ff);
      act_const  = act_london || active(block_number, constantinople_ff);
      act_byz    = act_const  || active(block_number, byzantium_ff);
      act_home   = act_byz    || active(block_number, homestead_ff);
      act_muir   = active(block_number, muir_glacier_ff);
      act_arrow  = active(block_number, arrow_glacier_ff);
      act_gray   = active(block_number, gray_glacier_ff);
      dt         = block_time - parent_time;

      item.block_number  = block_number;
      item.dt            = dt;
      item.parent_diff   = parent_diff;
      item.uncles        = parent_uncles;
      item.is_byz        = act_byz;
      item.is_home       = act_home;
      item.frontier_fast = dt < 32'(FRONTIER_FAST_DT);

      // first matching delay wins
      if (act_gray)        item.delay = DELAY_GRAY_GLACIER;
      else if (act_arrow)  item.delay = DELAY_ARROW_GLACIER;
      else if (act_london) item.delay = DELAY_LONDON;
      else if (act_muir)   item.delay = DELAY_MUIR_GLACIER;
      else if (act_const)  item.delay = DELAY_CONSTANTINOPLE;
      else if (act_byz)    item.delay = DELAY_BYZANTIUM;
      else                 item.delay = '0;
   end

endmodule

`default_nettype wire

>>> rtl/pda_queue.sv
`default_nettype none

module pda_queue
   import pda_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire pda_item_type push_item,
   output logic        full,
   input  wire logic   pop,
   output logic        empty,
   output pda_item_type head
);

   pda_item_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_BITS:0]      count_ff;

   assign full  = count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

`default_nettype wire

>>> rtl/pda_back.sv
`default_nettype none

module pda_back
   import pda_pkg::*;
#(
   parameter int DIFFICULTY_BITS = 64
)
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   q_empty,
   input  wire pda_item_type q_head,
   output logic        q_pop,
   output logic        rsp_valid,
   input  wire logic   rsp_ready,
   output logic [63:0] rsp_new_diff,
   output logic        rsp_overflowed
);

   localparam int DB = DIFFICULTY_BITS;
   localparam int XW = DB - 11;
   localparam int PW = DB - 4;
   localparam int SW = $clog2(DB);

   logic adv;
   assign adv   = !rsp_valid || rsp_ready;
   assign q_pop = adv && !q_empty;

   // stage 1: x, parent - 99x, reciprocal product, delayed number
   logic          s1_valid_ff;
   logic [XW-1:0] s1_x_ff;
   logic [DB-1:0] s1_p_ff;
   logic [22:0]   s1_q_ff;
   logic          s1_small_ff, s1_byz_ff, s1_home_ff, s1_fast_ff, s1_unc_ff;
   logic [31:0]   s1_eff_ff;

   logic [DB-1:0] pd, x99;
   logic [XW-1:0] x_in;
   logic [12:0]   recip;
   logic [22:0]   q_in;
   logic [31:0]   eff_in, delay32;

   always_comb begin
      pd      = q_head.parent_diff[DB-1:0];
      x_in    = pd[DB-1:11];
      x99     = DB'(x_in) * DB'(ADJ_FLOOR);
      recip   = q_head.is_byz ? RECIP_DIV9 : RECIP_DIV10;
      q_in    = 23'(q_head.dt[9:0]) * 23'(recip);
      delay32 = 32'(q_head.delay);
      eff_in  = (q_head.block_number > delay32) ? q_head.block_number - delay32 : '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x_ff     <= x_in;
         s1_p_ff     <= pd - x99;
         s1_q_ff     <= q_in;
         s1_small_ff <= q_head.dt[31:10] == '0;
         s1_byz_ff   <= q_head.is_byz;
         s1_home_ff  <= q_head.is_home;
         s1_fast_ff  <= q_head.frontier_fast;
         s1_unc_ff   <= q_head.uncles;
         s1_eff_ff   <= eff_in;
      end
   end

   // stage 2: multiplier k and bomb period
   logic          s2_valid_ff;
   logic [XW-1:0] s2_x_ff;
   logic [DB-1:0] s2_p_ff;
   logic [6:0]    s2_m_ff, s2_n_ff;
   logic          s2_big_ff;

   logic [6:0]  z, base, m_in;
   logic [46:0] n_prod;

   always_comb begin
      z    = s1_small_ff ? s1_q_ff[22:16] : 7'd127;
      base = (s1_byz_ff && s1_unc_ff) ? 7'd101 : 7'd100;
      if (!s1_home_ff)   m_in = s1_fast_ff ? 7'd100 : 7'd98;
      else if (base > z) m_in = base - z;
      else               m_in = '0;
      n_prod = 47'(s1_eff_ff[22:0]) * 47'(RECIP_PERIOD);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_x_ff   <= s1_x_ff;
         s2_p_ff   <= s1_p_ff;
         s2_m_ff   <= m_in;
         s2_n_ff   <= n_prod[46:40];
         s2_big_ff <= s1_eff_ff[31:23] != '0;
      end
   end

   // stage 3: k*x and bomb exponent
   logic          s3_valid_ff;
   logic [DB-1:0] s3_p_ff;
   logic [PW-1:0] s3_prod_ff;
   logic          s3_bomb_ff, s3_bovf_ff;
   logic [SW-1:0] s3_sh_ff;

   logic [6:0] sh7;
   assign sh7 = s2_n_ff - 7'd2;

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_p_ff    <= s2_p_ff;
         s3_prod_ff <= PW'(s2_m_ff) * PW'(s2_x_ff);
         s3_bomb_ff <= s2_big_ff || (s2_n_ff >= 7'd2);
         s3_bovf_ff <= s2_big_ff || (sh7 >= 7'(DB));
         s3_sh_ff   <= sh7[SW-1:0];
      end
   end

   // stage 4: adjusted difficulty
   logic          s4_valid_ff;
   logic [DB-1:0] s4_d_ff;
   logic          s4_ovf_ff, s4_bomb_ff, s4_bovf_ff;
   logic [SW-1:0] s4_sh_ff;
   logic [DB:0]   sum;

   assign sum = (DB+1)'(s3_p_ff) + (DB+1)'(s3_prod_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_d_ff    <= sum[DB-1:0];
         s4_ovf_ff  <= sum[DB];
         s4_bomb_ff <= s3_bomb_ff;
         s4_bovf_ff <= s3_bovf_ff;
         s4_sh_ff   <= s3_sh_ff;
      end
   end

   // output: bomb term, saturation, floor
   logic [DB:0]   bomb_val, d2;
   logic          ovf;
   logic [DB-1:0] clamped;

   always_comb begin
      bomb_val = s4_bomb_ff ? ((DB+1)'(1) << s4_sh_ff) : '0;
      d2       = {1'b0, s4_d_ff} + bomb_val;
      ovf      = s4_ovf_ff || (s4_bomb_ff && (s4_bovf_ff || d2[DB]));
      clamped  = (d2[DB-1:0] < DB'(MIN_DIFF)) ? DB'(MIN_DIFF) : d2[DB-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_new_diff   <= ovf ? 64'({DB{1'b1}}) : 64'(clamped);
         rsp_overflowed <= ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         rsp_valid   <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= !q_empty;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         rsp_valid   <= s4_valid_ff;
      end
   end

endmodule

`default_nettype wire

>>> rtl/pow_difficulty_adjust_top.sv
`default_nettype none

// Proof-of-work difficulty adjustment, one header summary in, one difficulty
// out. Each req transaction carries the block number, both timestamps, the
// parent difficulty and the parent-has-uncles flag; the fork rule (Frontier,
// Homestead or Byzantium), the bomb delay and the exponential bomb term are
// taken from the seven fork-start registers on the csr port (index 0 homestead
// through 6 gray glacier, reset all ones = never). Result is floored at 0x20000
// and saturates to all ones within DIFFICULTY_BITS with overflowed set.
// Rate: one transaction per cycle while rsp_tready is high. The accepting
// edge writes the four-entry queue behind the classifier; from there an item
// passes the back-end stages (the 99x/reciprocal multiply, the k and period
// select, the k*x multiply, the wide add) and then the output register that
// drives rsp_tvalid. req_tready drops only when the queue is full; behind a
// steady stream, a held rsp transaction stalls the back end until the queue
// fills and req_tready goes low.
// Write csr only while idle.

module pow_difficulty_adjust_top
   import pda_pkg::*;
#(
   parameter int DIFFICULTY_BITS = 64
)
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // csr write port
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   // header stream
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // [31:0] block_number, [63:32] block_time, [95:64] parent_time,
   // [159:96] parent_diff, [160] parent_uncles, [167:161] zero
   input  wire logic [167:0]              req_tdata,
   // difficulty stream
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // [63:0] new_diff, [64] overflowed, [71:65] zero
   output logic [71:0]                    rsp_tdata
);

   pda_item_type front_item, q_head;
   logic         q_full, q_empty, q_pop, push;
   logic [63:0]  new_diff;
   logic         overflowed;

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   // classify: fork flags, bomb delay, time delta
   pda_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .block_number  (req_tdata[31:0]),
      .block_time    (req_tdata[63:32]),
      .parent_time   (req_tdata[95:64]),
      .parent_diff   (req_tdata[159:96]),
      .parent_uncles (req_tdata[160]),
      .item          (front_item)
   );

   pda_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   // arithmetic pipeline, stalls as a whole on rsp backpressure
   pda_back #(
      .DIFFICULTY_BITS (DIFFICULTY_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_new_diff   (new_diff),
      .rsp_overflowed (overflowed)
   );

   assign rsp_tdata = {7'b0, overflowed, new_diff};

endmodule

`default_nettype wire
